// ===== hdl/dwc_pkg.sv =====
// Shared constants and types for the depthwise 3x3 convolution core.
// No dependencies; imported by every module of the core.
`default_nettype none

package dwc_pkg;

  // Default plane limits, handed to the top level as parameter defaults
  localparam int DefMaxWidth  = 256;
  localparam int DefMaxHeight = 4096;

  // Fixed field widths
  localparam int PixW  = 16;   // signed Q8.8 pixel
  localparam int WgtW  = 16;   // signed Q3.13 weight
  localparam int ProdW = 32;   // one tap product
  localparam int PartW = 34;   // sum of one kernel row of products
  localparam int SumW  = 36;   // signed Q15.21 result
  localparam int KDim  = 3;
  localparam int Taps  = KDim * KDim;

  // Configuration port
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 48;
  localparam int PlaneWidthRegW  = 9;
  localparam int PlaneHeightRegW = 13;
  localparam int RowWeightsW     = KDim * WgtW;

  localparam logic [PlaneWidthRegW-1:0]  PlaneWidthReset  = PlaneWidthRegW'(256);
  localparam logic [PlaneHeightRegW-1:0] PlaneHeightReset = PlaneHeightRegW'(256);

  typedef enum logic [CfgIdxW-1:0] {
    REG_PLANE_WIDTH    = 3'd0,
    REG_PLANE_HEIGHT   = 3'd1,
    REG_WEIGHTS_TOP    = 3'd2,
    REG_WEIGHTS_MIDDLE = 3'd3,
    REG_WEIGHTS_BOTTOM = 3'd4
  } cfg_reg_t;

  // Job queue between front and back
  localparam int QueueDepth = 4;
  localparam int QLevelW    = $clog2(QueueDepth + 1);

  // Results that one pixel owes, in emission order from the lowest bit up
  typedef struct packed {
    logic cur_here;   // (r, c), final output of the plane
    logic cur_left;   // (r, c-1)
    logic up_here;    // (r-1, c)
    logic up_left;    // (r-1, c-1)
  } emit_t;

endpackage

`default_nettype wire

// ===== hdl/dwc_front.sv =====
// Front end: configuration registers, pixel intake, line store, 3x3 window
// and classification of each pixel into the results it owes. Uses dwc_pkg.
`default_nettype none

module dwc_front #(
  parameter int MAX_WIDTH  = dwc_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = dwc_pkg::DefMaxHeight,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int WB = $clog2(MAX_WIDTH + 1),
  localparam int HB = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                                            clk,
  input  logic                                            rst,
  // configuration writes
  input  logic                                            cfg_valid,
  output logic                                            cfg_ready,
  input  logic [dwc_pkg::CfgIdxW-1:0]                     cfg_index,
  input  logic [dwc_pkg::CfgDataW-1:0]                    cfg_data,
  // pixel intake
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic [dwc_pkg::PixW-1:0]                        in_pixel,
  // job queue
  input  logic [dwc_pkg::QLevelW-1:0]                     q_level,
  output logic                                            push,
  output logic [dwc_pkg::Taps-1:0][dwc_pkg::PixW-1:0]     push_taps,
  output logic [RW-1:0]                                   push_row,
  output logic [CW-1:0]                                   push_col,
  output dwc_pkg::emit_t                                  push_emit,
  // geometry and weights for the back end
  output logic [WB-1:0]                                   geo_width,
  output logic [HB-1:0]                                   geo_height,
  output logic [dwc_pkg::RowWeightsW-1:0]                 weights_top,
  output logic [dwc_pkg::RowWeightsW-1:0]                 weights_middle,
  output logic [dwc_pkg::RowWeightsW-1:0]                 weights_bottom
);
  import dwc_pkg::*;

  logic [PlaneWidthRegW-1:0]  plane_width;
  logic [PlaneHeightRegW-1:0] plane_height;

  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count;

  logic          accept;
  logic          last_col;
  logic          last_row;
  emit_t         emit_now;

  // stage after intake: line store data arrives here
  logic          s1_valid;
  logic [PixW-1:0] s1_pixel;
  logic [RW-1:0] s1_row;
  logic [CW-1:0] s1_col;
  emit_t         s1_emit;

  logic [2*PixW-1:0] line_mem [MAX_WIDTH];
  logic [2*PixW-1:0] line_rd;
  logic [2*PixW-1:0] line_word;
  logic [2*PixW-1:0] line_wr;
  logic [2*PixW-1:0] fwd_data;
  logic              fwd_hit;

  logic [Taps-1:0][PixW-1:0] window;
  logic [Taps-1:0][PixW-1:0] window_next;

  assign cfg_ready = 1'b1;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_width    <= PlaneWidthReset;
      plane_height   <= PlaneHeightReset;
      weights_top    <= '0;
      weights_middle <= '0;
      weights_bottom <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PLANE_WIDTH:    plane_width    <= cfg_data[PlaneWidthRegW-1:0];
        REG_PLANE_HEIGHT:   plane_height   <= cfg_data[PlaneHeightRegW-1:0];
        REG_WEIGHTS_TOP:    weights_top    <= cfg_data[RowWeightsW-1:0];
        REG_WEIGHTS_MIDDLE: weights_middle <= cfg_data[RowWeightsW-1:0];
        REG_WEIGHTS_BOTTOM: weights_bottom <= cfg_data[RowWeightsW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry: zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (plane_width == '0) begin
      geo_width = WB'(1);
    end else if (32'(plane_width) > 32'(MAX_WIDTH)) begin
      geo_width = WB'(MAX_WIDTH);
    end else begin
      geo_width = WB'(plane_width);
    end
    if (plane_height == '0) begin
      geo_height = HB'(1);
    end else if (32'(plane_height) > 32'(MAX_HEIGHT)) begin
      geo_height = HB'(MAX_HEIGHT);
    end else begin
      geo_height = HB'(plane_height);
    end
  end

  // Take a word only when the queue has room for it and for the one in flight
  assign in_ready = ({1'b0, q_level} + (QLevelW + 1)'(s1_valid)) < (QLevelW + 1)'(QueueDepth);
  assign accept   = in_valid && in_ready;

  // Classify the current position
  assign last_col = (32'(col_count) + 32'd1) >= 32'(geo_width);
  assign last_row = (32'(row_count) + 32'd1) >= 32'(geo_height);

  always_comb begin
    emit_now.up_left  = (row_count != '0) && (col_count != '0);
    emit_now.up_here  = (row_count != '0) && last_col;
    emit_now.cur_left = last_row && (col_count != '0);
    emit_now.cur_here = last_row && last_col;
  end

  // Advance the raster counters and the intake stage
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      s1_valid  <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      s1_valid <= accept;
      fwd_hit  <= accept && s1_valid && (col_count == s1_col);
      if (accept) begin
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + RW'(1);
        end else begin
          col_count <= col_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= in_pixel;
      s1_row   <= row_count;
      s1_col   <= col_count;
      s1_emit  <= emit_now;
    end
  end

  // Line store: older row in the high half, newer row in the low half
  assign line_word = fwd_hit ? fwd_data : line_rd;
  assign line_wr   = {line_word[PixW-1:0], s1_pixel};

  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[col_count];
    end
    if (s1_valid) begin
      line_mem[s1_col] <= line_wr;
    end
  end

  // Keep the word just written for a read of the same column in that cycle
  always_ff @(posedge clk) begin
    fwd_data <= line_wr;
  end

  // Shift the window one column and load the new right column
  always_comb begin
    for (int k = 0; k < KDim; k++) begin
      window_next[k*KDim + 0] = window[k*KDim + 1];
      window_next[k*KDim + 1] = window[k*KDim + 2];
    end
    window_next[2] = line_word[2*PixW-1:PixW];
    window_next[5] = line_word[PixW-1:0];
    window_next[8] = s1_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_valid) begin
      window <= window_next;
    end
  end

  // Hand a job to the back end only when the pixel owes results
  assign push      = s1_valid && (|s1_emit);
  assign push_taps = window_next;
  assign push_row  = s1_row;
  assign push_col  = s1_col;
  assign push_emit = s1_emit;

endmodule

`default_nettype wire

// ===== hdl/dwc_queue.sv =====
// Short job queue that decouples the front end from the back end.
// Register array with one read at the head pointer. Uses dwc_pkg.
`default_nettype none

module dwc_queue #(
  parameter int WIDTH = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [WIDTH-1:0]            push_data,
  input  logic                        pop,
  output logic [WIDTH-1:0]            head,
  output logic [dwc_pkg::QLevelW-1:0] level
);
  import dwc_pkg::*;

  localparam int AW = $clog2(QueueDepth);

  logic [WIDTH-1:0] slots [QueueDepth];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  // Advance pointers and the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + QLevelW'(1);
        2'b01:   level <= level - QLevelW'(1);
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head = slots[rd_ptr];

endmodule

`default_nettype wire

// ===== hdl/dwc_back.sv =====
// Back end: walks the results each job owes, masks the taps, picks the
// weights and runs the nine-tap multiply-accumulate pipeline. Uses dwc_pkg.
`default_nettype none

module dwc_back #(
  parameter int MAX_WIDTH  = dwc_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = dwc_pkg::DefMaxHeight,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int WB = $clog2(MAX_WIDTH + 1),
  localparam int HB = $clog2(MAX_HEIGHT + 1),
  localparam int OUT_DW = ((dwc_pkg::SumW + RW + CW + 7) / 8) * 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  // job queue head
  input  logic [dwc_pkg::QLevelW-1:0]                 q_level,
  input  logic [dwc_pkg::Taps-1:0][dwc_pkg::PixW-1:0] head_taps,
  input  logic [RW-1:0]                               head_row,
  input  logic [CW-1:0]                               head_col,
  input  dwc_pkg::emit_t                              head_emit,
  output logic                                        pop,
  // geometry and weights
  input  logic [WB-1:0]                               geo_width,
  input  logic [HB-1:0]                               geo_height,
  input  logic [dwc_pkg::RowWeightsW-1:0]             weights_top,
  input  logic [dwc_pkg::RowWeightsW-1:0]             weights_middle,
  input  logic [dwc_pkg::RowWeightsW-1:0]             weights_bottom,
  // result stream
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [OUT_DW-1:0]                           out_data,
  output logic                                        out_last,
  output logic                                        out_done
);
  import dwc_pkg::*;

  logic                 q_valid;
  logic                 advance;
  logic [3:0]           served;
  logic [3:0]           pend;
  logic [3:0]           sel;
  logic [3:0]           rest;
  logic                 is_last;
  logic                 dr;
  logic                 dc;
  logic [RW-1:0]        sel_row;
  logic [CW-1:0]        sel_col;
  logic [KDim-1:0]      row_ok;
  logic [KDim-1:0]      col_ok;
  logic [1:0]           row_pick [KDim];
  logic [1:0]           col_pick [KDim];
  logic [WgtW-1:0]      wgt [KDim][KDim];
  logic [RowWeightsW-1:0] wrow [KDim];
  logic [PixW-1:0]      tap_sel [Taps];
  logic [WgtW-1:0]      wgt_sel [Taps];

  // select stage
  logic                 v0;
  logic [PixW-1:0]      b0_tap [Taps];
  logic [WgtW-1:0]      b0_wgt [Taps];
  logic [RW-1:0]        b0_row;
  logic [CW-1:0]        b0_col;
  logic                 b0_last;
  logic                 b0_done;
  logic signed [ProdW-1:0] tap_x [Taps];
  logic signed [ProdW-1:0] wgt_x [Taps];

  // product stage
  logic                 v1;
  logic signed [ProdW-1:0] prod [Taps];
  logic [RW-1:0]        b1_row;
  logic [CW-1:0]        b1_col;
  logic                 b1_last;
  logic                 b1_done;

  // partial-sum stage
  logic                 v2;
  logic signed [PartW-1:0] part [KDim];
  logic [RW-1:0]        b2_row;
  logic [CW-1:0]        b2_col;
  logic                 b2_last;
  logic                 b2_done;
  logic signed [SumW-1:0] total;

  assign q_valid = (q_level != '0);
  // Whole pipeline moves when the output register is free or being taken
  assign advance = !out_valid || out_ready;

  // Pick the next result the head job still owes
  always_comb begin
    pend    = head_emit & ~served;
    sel     = pend & (~pend + 4'd1);
    rest    = pend & ~sel;
    is_last = (rest == '0);
    dr      = sel[2] | sel[3];
    dc      = sel[1] | sel[3];
    sel_row = head_row - RW'(1) + RW'(dr);
    sel_col = head_col - CW'(1) + CW'(dc);
  end

  assign pop = advance && q_valid && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      served <= '0;
    end else if (advance && q_valid) begin
      served <= is_last ? '0 : (served | sel);
    end
  end

  // Split the weight registers into a 3x3 grid
  assign wrow[0] = weights_top;
  assign wrow[1] = weights_middle;
  assign wrow[2] = weights_bottom;

  always_comb begin
    for (int i = 0; i < KDim; i++) begin
      for (int j = 0; j < KDim; j++) begin
        wgt[i][j] = wrow[i][WgtW*j +: WgtW];
      end
    end
  end

  // Mask taps outside the plane or outside this output's kernel
  always_comb begin
    for (int k = 0; k < KDim; k++) begin
      row_ok[k] = (k >= int'(dr))
               && ((32'(head_row) + 32'(k)) >= 32'd2)
               && ((32'(head_row) + 32'(k)) < (32'(geo_height) + 32'd2));
      col_ok[k] = (k >= int'(dc))
               && ((32'(head_col) + 32'(k)) >= 32'd2)
               && ((32'(head_col) + 32'(k)) < (32'(geo_width) + 32'd2));
      row_pick[k] = (dr && (k != 0)) ? 2'(k - 1) : 2'(k);
      col_pick[k] = (dc && (k != 0)) ? 2'(k - 1) : 2'(k);
    end
    for (int i = 0; i < KDim; i++) begin
      for (int j = 0; j < KDim; j++) begin
        tap_sel[i*KDim + j] = (row_ok[i] && col_ok[j]) ? head_taps[i*KDim + j] : '0;
        wgt_sel[i*KDim + j] = wgt[row_pick[i]][col_pick[j]];
      end
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v0        <= q_valid;
      v1        <= v0;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Register the selected taps and weights
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int t = 0; t < Taps; t++) begin
        b0_tap[t] <= tap_sel[t];
        b0_wgt[t] <= wgt_sel[t];
      end
      b0_row  <= sel_row;
      b0_col  <= sel_col;
      b0_last <= is_last;
      b0_done <= sel[3];
    end
  end

  // Nine parallel products
  always_comb begin
    for (int t = 0; t < Taps; t++) begin
      tap_x[t] = {{(ProdW-PixW){b0_tap[t][PixW-1]}}, b0_tap[t]};
      wgt_x[t] = {{(ProdW-WgtW){b0_wgt[t][WgtW-1]}}, b0_wgt[t]};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int t = 0; t < Taps; t++) begin
        prod[t] <= tap_x[t] * wgt_x[t];
      end
      b1_row  <= b0_row;
      b1_col  <= b0_col;
      b1_last <= b0_last;
      b1_done <= b0_done;
    end
  end

  // Add each window row of products
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < KDim; k++) begin
        part[k] <= {{(PartW-ProdW){prod[k*KDim + 0][ProdW-1]}}, prod[k*KDim + 0]}
                 + {{(PartW-ProdW){prod[k*KDim + 1][ProdW-1]}}, prod[k*KDim + 1]}
                 + {{(PartW-ProdW){prod[k*KDim + 2][ProdW-1]}}, prod[k*KDim + 2]};
      end
      b2_row  <= b1_row;
      b2_col  <= b1_col;
      b2_last <= b1_last;
      b2_done <= b1_done;
    end
  end

  // Final sum into the output register
  assign total = {{(SumW-PartW){part[0][PartW-1]}}, part[0]}
               + {{(SumW-PartW){part[1][PartW-1]}}, part[1]}
               + {{(SumW-PartW){part[2][PartW-1]}}, part[2]};

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= OUT_DW'({b2_col, b2_row, total});
      out_last <= b2_last;
      out_done <= b2_done;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/depthwise_conv3x3_same_pad_core.sv =====
// Top level of the depthwise 3x3 convolution core (stride 1, zero pad 1).
// Instantiates dwc_front, dwc_queue and dwc_back; uses dwc_pkg.
//
//  Channel   Dir  Handshake                   Payload
//  cfg       in   cfg_valid / cfg_ready       cfg_index, cfg_data
//  s_axis    in   s_axis_tvalid / tready      tdata: pixel
//  m_axis    out  m_axis_tvalid / tready      tdata: value, row, col;
//                                             tlast: last of pixel; tuser: plane done
//
// One pixel a cycle is taken while the four-entry job queue has room; a pixel
// owing k results (k up to four on the last row) holds the back end while its
// results issue, one result a cycle from the nine-multiplier pipeline unless
// the output stalls. A result passes the intake, queue, select, product,
// partial-sum and output registers. Reset is synchronous; the line store
// is not cleared and needs no sweep. A stalled output holds the whole back
// pipeline; the front keeps filling the queue until it is full.
`default_nettype none

module depthwise_conv3x3_same_pad_core #(
  parameter int MAX_WIDTH  = dwc_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = dwc_pkg::DefMaxHeight,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int OUT_DW = ((dwc_pkg::SumW + RW + CW + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dwc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dwc_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [dwc_pkg::PixW-1:0]     s_axis_tdata,   // [15:0] pixel
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OUT_DW-1:0]            m_axis_tdata,   // result_value, out_row, out_col
  output logic                         m_axis_tlast,   // last_in_run
  output logic                         m_axis_tuser    // plane_done
);
  import dwc_pkg::*;

  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int JOB_W = $bits(emit_t) + CW + RW + Taps * PixW;

  logic                      q_push;
  logic                      q_pop;
  logic [QLevelW-1:0]        q_level;
  logic [Taps-1:0][PixW-1:0] push_taps;
  logic [RW-1:0]             push_row;
  logic [CW-1:0]             push_col;
  emit_t                     push_emit;
  logic [JOB_W-1:0]          push_job;
  logic [JOB_W-1:0]          head_job;
  logic [Taps-1:0][PixW-1:0] head_taps;
  logic [RW-1:0]             head_row;
  logic [CW-1:0]             head_col;
  emit_t                     head_emit;
  logic [WB-1:0]             geo_width;
  logic [HB-1:0]             geo_height;
  logic [RowWeightsW-1:0]    weights_top;
  logic [RowWeightsW-1:0]    weights_middle;
  logic [RowWeightsW-1:0]    weights_bottom;

  dwc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_pixel       (s_axis_tdata),
    .q_level        (q_level),
    .push           (q_push),
    .push_taps      (push_taps),
    .push_row       (push_row),
    .push_col       (push_col),
    .push_emit      (push_emit),
    .geo_width      (geo_width),
    .geo_height     (geo_height),
    .weights_top    (weights_top),
    .weights_middle (weights_middle),
    .weights_bottom (weights_bottom)
  );

  // Pack and unpack a job word
  assign push_job = {push_emit, push_col, push_row, push_taps};
  assign {head_emit, head_col, head_row, head_taps} = head_job;

  dwc_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_job),
    .pop       (q_pop),
    .head      (head_job),
    .level     (q_level)
  );

  dwc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_level        (q_level),
    .head_taps      (head_taps),
    .head_row       (head_row),
    .head_col       (head_col),
    .head_emit      (head_emit),
    .pop            (q_pop),
    .geo_width      (geo_width),
    .geo_height     (geo_height),
    .weights_top    (weights_top),
    .weights_middle (weights_middle),
    .weights_bottom (weights_bottom),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_data       (m_axis_tdata),
    .out_last       (m_axis_tlast),
    .out_done       (m_axis_tuser)
  );

  // Queue credit keeps a push from landing in a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_level < QLevelW'(QueueDepth)))
    else $error("job pushed into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_level != '0))
    else $error("job popped from an empty queue");

  // The plane's final output is always the last result of its pixel
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("plane done without end of run");

endmodule

`default_nettype wire
